### rtl/assert_macros.svh
// Assertion helpers for the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Check that a condition implies another in the following cycle
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, cond)
`define ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### rtl/jst_pkg.sv
`default_nettype none
package jst_pkg;

  localparam int DefMaxDepth = 32;

  typedef enum logic [3:0] {
    EV_STR_CH     = 4'd0,
    EV_KEY_CH     = 4'd1,
    EV_NUM_CH     = 4'd2,
    EV_STR_END    = 4'd3,
    EV_KEY_END    = 4'd4,
    EV_NUM_END    = 4'd5,
    EV_TRUE       = 4'd6,
    EV_FALSE      = 4'd7,
    EV_NULL       = 4'd8,
    EV_ENTER_LIST = 4'd9,
    EV_EXIT_LIST  = 4'd10,
    EV_ENTER_MAP  = 4'd11,
    EV_EXIT_MAP   = 4'd12,
    EV_ERROR      = 4'd13,
    EV_FINISH     = 4'd14
  } ev_t;

  typedef enum logic [4:0] {
    M_IDLE      = 5'd0,
    M_OPEN_LIST = 5'd1,
    M_OPEN_MAP  = 5'd2,
    M_STR       = 5'd3,
    M_KEY       = 5'd4,
    M_COLON     = 5'd5,
    M_N_SIGN    = 5'd6,
    M_N_ZERO    = 5'd7,
    M_N_INT     = 5'd8,
    M_N_DOT     = 5'd9,
    M_N_FRAC    = 5'd10,
    M_N_EXP     = 5'd11,
    M_N_ESIGN   = 5'd12,
    M_N_EDIG    = 5'd13,
    M_LIT_T     = 5'd14,
    M_LIT_F     = 5'd15,
    M_LIT_N     = 5'd16
  } mode_t;

  typedef enum logic [1:0] {
    S_IN     = 2'd0,
    S_SECOND = 2'd1,
    S_DRAIN  = 2'd2
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_byte;
    logic take_end;
    logic emit_second;
    logic emit_exit;
    logic emit_finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic two_events;
    logic lvl_zero;
  } status_t;

  // Letters of true, false and null
  function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (w)
      2'd0: case (i)
        3'd0: c = "t";
        3'd1: c = "r";
        3'd2: c = "u";
        3'd3: c = "e";
        default: c = 8'h00;
      endcase
      2'd1: case (i)
        3'd0: c = "f";
        3'd1: c = "a";
        3'd2: c = "l";
        3'd3: c = "s";
        3'd4: c = "e";
        default: c = 8'h00;
      endcase
      2'd2: case (i)
        3'd0: c = "n";
        3'd1: c = "u";
        3'd2: c = "l";
        3'd3: c = "l";
        default: c = 8'h00;
      endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] w);
    return (w == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage
`default_nettype wire

### rtl/jst_ctrl.sv
`default_nettype none
module jst_ctrl
  import jst_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  input  wire logic    in_kind,
  output logic         in_ready,
  input  wire status_t st,
  output cmd_t         cmd
);

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  // Sequence items and extra results
  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IN: begin
        in_ready = st.out_free;
        if (in_valid && st.out_free) begin
          if (in_kind) begin
            cmd.take_end = 1'b1;
            state_next = S_DRAIN;
          end else begin
            cmd.take_byte = 1'b1;
            if (st.two_events) state_next = S_SECOND;
          end
        end
      end
      S_SECOND: begin
        if (st.out_free) begin
          cmd.emit_second = 1'b1;
          state_next = S_IN;
        end
      end
      S_DRAIN: begin
        if (st.out_free) begin
          if (!st.lvl_zero) begin
            cmd.emit_exit = 1'b1;
          end else begin
            cmd.emit_finish = 1'b1;
            state_next = S_IN;
          end
        end
      end
      default: state_next = S_IN;
    endcase
  end

endmodule
`default_nettype wire

### rtl/jst_dpath.sv
`default_nettype none
module jst_dpath
  import jst_pkg::*;
#(
  parameter int MAX_DEPTH = DefMaxDepth
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cmd_t       cmd,
  output status_t         st,
  input  wire logic [7:0] in_byte,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [3:0]      out_ev,
  output logic [7:0]      out_ch,
  output logic            out_last
);

  localparam int LvlW = $clog2(MAX_DEPTH + 1);
  localparam int IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Lexer state
  logic            stack [MAX_DEPTH];
  logic [LvlW-1:0] lvl, lvl_next, lvl_m1;
  mode_t           mode, mode_next;
  logic            ek, ek_next, av, av_next, err, err_next;
  logic [2:0]      li, li_next;
  ev_t             sec_ev;

  // Byte decode
  logic b_ws, b_dig, b_ex, top, top_map, top_list, lvl_full;
  logic v1, v2, push, push_map;
  ev_t  e1, e2;
  logic [7:0] c1;
  logic sep_err, sep_emit, sep_comma;
  ev_t  sep_ev;
  logic sep_go, key_go, val_go, may_close, num_done, num_adv;
  mode_t num_nm;
  logic [1:0] lw;
  logic head_v, load;
  ev_t  head_ev;

  assign lvl_m1   = lvl - 1'b1;
  assign top      = stack[lvl_m1[IdxW-1:0]];
  assign top_map  = (lvl != '0) && top;
  assign top_list = (lvl != '0) && !top;
  assign lvl_full = (lvl == LvlW'(MAX_DEPTH));

  assign b_ws  = (in_byte == 8'd32) || (in_byte == 8'd9) || (in_byte == 8'd10) ||
                 (in_byte == 8'd13);
  assign b_dig = (in_byte >= "0") && (in_byte <= "9");
  assign b_ex  = (in_byte == "e") || (in_byte == "E");

  // Separator after a complete value
  always_comb begin
    sep_err = 1'b0;
    sep_emit = 1'b0;
    sep_comma = 1'b0;
    sep_ev = EV_EXIT_LIST;
    if (b_ws) begin
      sep_err = 1'b0;
    end else if (in_byte == ",") begin
      if (lvl == '0) sep_err = 1'b1;
      else sep_comma = 1'b1;
    end else if (in_byte == "]") begin
      if (top_list) sep_emit = 1'b1;
      else sep_err = 1'b1;
    end else if (in_byte == "}") begin
      sep_ev = EV_EXIT_MAP;
      if (top_map) sep_emit = 1'b1;
      else sep_err = 1'b1;
    end else begin
      sep_err = 1'b1;
    end
  end

  // Number grammar step
  always_comb begin
    num_adv = 1'b1;
    num_nm = mode;
    if (mode == M_N_SIGN && b_dig) begin
      num_nm = (in_byte == "0") ? M_N_ZERO : M_N_INT;
    end else if ((mode == M_N_ZERO || mode == M_N_INT) && in_byte == ".") begin
      num_nm = M_N_DOT;
    end else if ((mode == M_N_ZERO || mode == M_N_INT || mode == M_N_FRAC) && b_ex) begin
      num_nm = M_N_EXP;
    end else if (mode == M_N_INT && b_dig) begin
      num_nm = M_N_INT;
    end else if ((mode == M_N_DOT || mode == M_N_FRAC) && b_dig) begin
      num_nm = M_N_FRAC;
    end else if (mode == M_N_EXP && (in_byte == "+" || in_byte == "-")) begin
      num_nm = M_N_ESIGN;
    end else if ((mode == M_N_EXP || mode == M_N_ESIGN || mode == M_N_EDIG) && b_dig) begin
      num_nm = M_N_EDIG;
    end else begin
      num_adv = 1'b0;
    end
  end

  assign num_done = (mode == M_N_ZERO) || (mode == M_N_INT) || (mode == M_N_FRAC) ||
                    (mode == M_N_EDIG);
  assign sep_go    = (mode == M_IDLE) && av;
  assign key_go    = ((mode == M_IDLE) && !av && ek) || (mode == M_OPEN_MAP);
  assign val_go    = ((mode == M_IDLE) && !av && !ek) || (mode == M_OPEN_LIST);
  assign may_close = (mode == M_OPEN_MAP) || (mode == M_OPEN_LIST);
  assign lw        = 2'(mode - M_LIT_T);

  // Next lexer state and events for one document byte
  always_comb begin
    lvl_next = lvl;
    mode_next = mode;
    ek_next = ek;
    av_next = av;
    li_next = li;
    err_next = err;
    v1 = 1'b0;
    e1 = EV_ERROR;
    c1 = 8'h00;
    v2 = 1'b0;
    e2 = EV_ERROR;
    push = 1'b0;
    push_map = 1'b0;
    if (err) begin
      v1 = 1'b0;
    end else if (sep_go) begin
      if (sep_err) begin
        v1 = 1'b1;
        err_next = 1'b1;
      end else if (sep_emit) begin
        v1 = 1'b1;
        e1 = sep_ev;
        lvl_next = lvl_m1;
      end else if (sep_comma) begin
        av_next = 1'b0;
        ek_next = top_map;
      end
    end else if (key_go) begin
      if (b_ws) begin
        v1 = 1'b0;
      end else if (may_close && in_byte == "}") begin
        v1 = 1'b1;
        if (top_map) begin
          e1 = EV_EXIT_MAP;
          lvl_next = lvl_m1;
          mode_next = M_IDLE;
          av_next = 1'b1;
          ek_next = 1'b0;
          li_next = '0;
        end else begin
          err_next = 1'b1;
        end
      end else if (in_byte == "\"") begin
        mode_next = M_KEY;
        ek_next = 1'b0;
      end else begin
        v1 = 1'b1;
        err_next = 1'b1;
      end
    end else if (val_go) begin
      if (b_ws) begin
        v1 = 1'b0;
      end else if (may_close && in_byte == "]") begin
        v1 = 1'b1;
        if (top_list) begin
          e1 = EV_EXIT_LIST;
          lvl_next = lvl_m1;
          mode_next = M_IDLE;
          av_next = 1'b1;
          ek_next = 1'b0;
          li_next = '0;
        end else begin
          err_next = 1'b1;
        end
      end else if (in_byte == "\"") begin
        mode_next = M_STR;
      end else if (in_byte == "[" || in_byte == "{") begin
        v1 = 1'b1;
        if (lvl_full) begin
          err_next = 1'b1;
        end else begin
          push = 1'b1;
          push_map = (in_byte == "{");
          lvl_next = lvl + 1'b1;
          e1 = push_map ? EV_ENTER_MAP : EV_ENTER_LIST;
          mode_next = push_map ? M_OPEN_MAP : M_OPEN_LIST;
          ek_next = push_map;
          av_next = 1'b0;
        end
      end else if (in_byte == "-" || b_dig) begin
        v1 = 1'b1;
        e1 = EV_NUM_CH;
        c1 = in_byte;
        mode_next = (in_byte == "-") ? M_N_SIGN : (in_byte == "0") ? M_N_ZERO : M_N_INT;
      end else if (in_byte == "t" || in_byte == "f" || in_byte == "n") begin
        mode_next = (in_byte == "t") ? M_LIT_T : (in_byte == "f") ? M_LIT_F : M_LIT_N;
        li_next = 3'd1;
      end else begin
        v1 = 1'b1;
        err_next = 1'b1;
      end
    end else begin
      case (mode)
        M_STR, M_KEY: begin
          v1 = 1'b1;
          if ((in_byte < 8'd32 && in_byte != 8'd9) || in_byte == "\\") begin
            err_next = 1'b1;
          end else if (in_byte == "\"") begin
            if (mode == M_KEY) begin
              e1 = EV_KEY_END;
              mode_next = M_COLON;
            end else begin
              e1 = EV_STR_END;
              mode_next = M_IDLE;
              av_next = 1'b1;
              ek_next = 1'b0;
              li_next = '0;
            end
          end else begin
            e1 = (mode == M_KEY) ? EV_KEY_CH : EV_STR_CH;
            c1 = in_byte;
          end
        end
        M_COLON: begin
          if (b_ws) begin
            v1 = 1'b0;
          end else if (in_byte == ":") begin
            mode_next = M_IDLE;
            av_next = 1'b0;
            ek_next = 1'b0;
          end else begin
            v1 = 1'b1;
            err_next = 1'b1;
          end
        end
        M_N_SIGN, M_N_ZERO, M_N_INT, M_N_DOT, M_N_FRAC, M_N_EXP, M_N_ESIGN,
        M_N_EDIG: begin
          v1 = 1'b1;
          if (num_adv) begin
            e1 = EV_NUM_CH;
            c1 = in_byte;
            mode_next = num_nm;
          end else if (num_done && !b_dig) begin
            // End the number, then treat the byte as a separator
            e1 = EV_NUM_END;
            mode_next = M_IDLE;
            av_next = 1'b1;
            ek_next = 1'b0;
            li_next = '0;
            if (sep_err) begin
              v2 = 1'b1;
              err_next = 1'b1;
            end else if (sep_emit) begin
              v2 = 1'b1;
              e2 = sep_ev;
              lvl_next = lvl_m1;
            end else if (sep_comma) begin
              av_next = 1'b0;
              ek_next = top_map;
            end
          end else begin
            err_next = 1'b1;
          end
        end
        M_LIT_T, M_LIT_F, M_LIT_N: begin
          if (li >= lit_len(lw) || in_byte != lit_char(lw, li)) begin
            v1 = 1'b1;
            err_next = 1'b1;
          end else begin
            li_next = li + 1'b1;
            if (li_next == lit_len(lw)) begin
              v1 = 1'b1;
              e1 = ev_t'(EV_TRUE + 4'(lw));
              mode_next = M_IDLE;
              av_next = 1'b1;
              ek_next = 1'b0;
              li_next = '0;
            end
          end
        end
        default: begin
          v1 = 1'b1;
          err_next = 1'b1;
        end
      endcase
    end
  end

  // Leading result of the end item
  always_comb begin
    head_v = 1'b0;
    head_ev = EV_ERROR;
    if (lvl != '0) begin
      head_v = 1'b1;
    end else if (!err) begin
      if (num_done) begin
        head_v = 1'b1;
        head_ev = EV_NUM_END;
      end else if (mode != M_IDLE) begin
        head_v = 1'b1;
      end
    end
  end

  assign load = (cmd.take_byte && v1) || (cmd.take_end && head_v) || cmd.emit_second ||
                cmd.emit_exit || cmd.emit_finish;

  assign st.out_free   = !out_valid || out_ready;
  assign st.two_events = v2;
  assign st.lvl_zero   = (lvl == '0);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      lvl <= '0;
      mode <= M_IDLE;
      ek <= 1'b0;
      av <= 1'b0;
      li <= '0;
      err <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take_byte) begin
        lvl <= lvl_next;
        mode <= mode_next;
        ek <= ek_next;
        av <= av_next;
        li <= li_next;
        err <= err_next;
      end else if (cmd.emit_exit) begin
        lvl <= lvl_m1;
      end else if (cmd.emit_finish) begin
        lvl <= '0;
        mode <= M_IDLE;
        ek <= 1'b0;
        av <= 1'b0;
        li <= '0;
        err <= 1'b0;
      end
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Nesting stack: push writes the new top
  always_ff @(posedge clk) begin
    if (cmd.take_byte && push) stack[lvl[IdxW-1:0]] <= push_map;
  end

  // Output item and held second result
  always_ff @(posedge clk) begin
    if (cmd.take_byte) sec_ev <= e2;
    if (cmd.take_byte && v1) begin
      out_ev <= e1;
      out_ch <= c1;
      out_last <= !v2;
    end else if (cmd.take_end && head_v) begin
      out_ev <= head_ev;
      out_ch <= 8'h00;
      out_last <= 1'b0;
    end else if (cmd.emit_second) begin
      out_ev <= sec_ev;
      out_ch <= 8'h00;
      out_last <= 1'b1;
    end else if (cmd.emit_exit) begin
      out_ev <= top ? EV_EXIT_MAP : EV_EXIT_LIST;
      out_ch <= 8'h00;
      out_last <= 1'b0;
    end else if (cmd.emit_finish) begin
      out_ev <= EV_FINISH;
      out_ch <= 8'h00;
      out_last <= 1'b1;
    end
  end

endmodule
`default_nettype wire

### rtl/json_stream_tokenizer.sv
`default_nettype none
`include "assert_macros.svh"
// Streaming JSON tokenizer. Feed document bytes (tuser 0) and then one end
// item (tuser 1); each byte gives zero, one or two events, the end item gives
// an optional error or number end, one exit per open level and finish. The
// last event of each input item carries tlast. A byte that ends a number and
// also closes a level or faults gives its second event from the S_SECOND
// state, since the controller places results one per cycle, while the output
// register is free, into a single output register. After an error, bytes give
// nothing until the end item, which restores the reset state.
module json_stream_tokenizer
  import jst_pkg::*;
#(
  parameter int MAX_DEPTH = DefMaxDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
  input  wire logic        s_tuser,   // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [3:0] event_res, [11:4] text_byte
  output logic             m_tlast    // last_of_run
);

  cmd_t       cmd;
  status_t    st;
  logic [3:0] out_ev;
  logic [7:0] out_ch;

  jst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  jst_dpath #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_byte   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_ev    (out_ev),
    .out_ch    (out_ch),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_ch, out_ev};

  // Checks
  `ASSERT_ALWAYS(a_ready_free, !s_tready || !m_tvalid || m_tready)
  `ASSERT_ALWAYS(a_one_cmd, $onehot0(cmd))
  `ASSERT_ALWAYS(a_finish_last, !(m_tvalid && m_tdata[3:0] == EV_FINISH) || m_tlast)
  `ASSERT_NEXT(a_end_drains, s_tvalid && s_tready && s_tuser, !s_tready)

endmodule
`default_nettype wire
